// ----- hdl/bdq_pkg.sv -----
// Shared constants for the bounded deque: default depth, command and status codes.
// No dependencies; imported by the channel interfaces, the deque module and the bench.
package bdq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- hdl/bdq_ifs.sv -----
// Valid/ready channel interfaces for the deque: command words in, result words out.
// Depends on bdq_pkg for field widths.
interface bdq_cmd_if
	import bdq_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] data_value;

	modport source (output valid, output command, output data_value, input ready);
	modport sink   (input valid, input command, input data_value, output ready);
endinterface

interface bdq_res_if
	import bdq_pkg::*;
#(
	parameter int COUNT_W = 5
);
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [COUNT_W-1:0]  fill_count;

	modport source (output valid, output status, output found, output fill_count, input ready);
	modport sink   (input valid, input status, input found, input fill_count, output ready);
endinterface

// ----- hdl/bdq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/bounded_deque_with_search.sv -----
// Bounded deque of signed 32-bit words held in a ring of CAPACITY entries, with a
// front pointer and a fill count kept in registers and the entries in one RAM.
// Each command word yields exactly one result word. Pushes, pops, unused codes and
// a search of an empty store finish in the cycle they are accepted. A search reads
// the stored entries front to back through the RAM's single read port, one per
// cycle, and stops at the first match or after the last stored entry.
// One command is in progress at a time; a new word is taken only when no result is
// waiting or the waiting one leaves in the same cycle, and no search is running.
// No clearing pass after reset.
// Depends on bdq_pkg, bdq_ifs and bdq_ram.
module bounded_deque_with_search
	import bdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int COUNT_W = $clog2(CAPACITY + 1)
) (
	input logic        clk,
	input logic        arst_n,
	bdq_cmd_if.sink    cmd,
	bdq_res_if.source  res
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_SEARCH = 2'b10
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    front_q;
	logic [COUNT_W-1:0]  count_q;
	logic [DATA_W-1:0]   key_q;
	logic [COUNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic                rd_valid_s1;

	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_q;
	logic [COUNT_W-1:0]  res_count_q;

	logic                accept;
	logic                is_full;
	logic                is_empty;
	logic [IDX_W-1:0]    front_dec;
	logic [IDX_W-1:0]    front_inc;
	logic [IDX_W-1:0]    rd_addr_inc;
	logic [COUNT_W:0]    back_sum;
	logic [IDX_W-1:0]    back_idx;

	logic [IDX_W-1:0]    nxt_front;
	logic [COUNT_W-1:0]  nxt_count;
	logic [STATUS_W-1:0] imm_status;
	logic                start_search;

	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic                issue;
	logic [DATA_W-1:0]   rd_data;
	logic                hit;
	logic                srch_done;

	assign cmd.ready = (state_q == S_IDLE) && (!res_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	assign is_full  = (count_q == COUNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign front_dec   = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc   = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
	assign rd_addr_inc = (rd_addr_q == IDX_W'(CAPACITY - 1)) ? '0 : rd_addr_q + 1'b1;

	assign back_sum = {1'b0, count_q} + (COUNT_W + 1)'(front_q);
	assign back_idx = (back_sum >= (COUNT_W + 1)'(CAPACITY))
		? IDX_W'(back_sum - (COUNT_W + 1)'(CAPACITY)) : IDX_W'(back_sum);

	always_comb begin
		nxt_front    = front_q;
		nxt_count    = count_q;
		imm_status   = ST_DONE;
		start_search = 1'b0;
		we           = 1'b0;
		waddr        = back_idx;
		case (cmd.command)
			CMD_PUSH_FRONT: begin
				if (is_full) begin
					imm_status = ST_FULL;
				end else begin
					nxt_front = front_dec;
					nxt_count = count_q + 1'b1;
					we        = 1'b1;
					waddr     = front_dec;
				end
			end
			CMD_PUSH_BACK: begin
				if (is_full) begin
					imm_status = ST_FULL;
				end else begin
					nxt_count = count_q + 1'b1;
					we        = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (is_empty) begin
					imm_status = ST_EMPTY;
				end else begin
					nxt_front = front_inc;
					nxt_count = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (is_empty) begin
					imm_status = ST_EMPTY;
				end else begin
					nxt_count = count_q - 1'b1;
				end
			end
			CMD_SEARCH: begin
				start_search = !is_empty;
			end
			default: begin
			end
		endcase
	end

	// search walk: one read issued per cycle, compared the cycle after
	assign issue     = (state_q == S_SEARCH) && (idx_q != count_q);
	assign hit       = rd_valid_s1 && (rd_data == key_q);
	assign srch_done = (state_q == S_SEARCH) && (hit || ((idx_q == count_q) && !rd_valid_s1));

	bdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we && accept),
		.waddr (waddr),
		.wdata ($unsigned(cmd.data_value)),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			rd_valid_s1 <= issue && !srch_done;
			if (issue) begin
				idx_q     <= idx_q + 1'b1;
				rd_addr_q <= rd_addr_inc;
			end
			if (accept) begin
				front_q <= nxt_front;
				count_q <= nxt_count;
				if (start_search) begin
					state_q   <= S_SEARCH;
					idx_q     <= '0;
					rd_addr_q <= front_q;
				end else begin
					res_valid_q <= 1'b1;
				end
			end
			if (srch_done) begin
				state_q     <= S_IDLE;
				res_valid_q <= 1'b1;
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= $unsigned(cmd.data_value);
			if (!start_search) begin
				res_status_q <= imm_status;
				res_found_q  <= 1'b0;
				res_count_q  <= nxt_count;
			end
		end
		if (srch_done) begin
			res_status_q <= ST_DONE;
			res_found_q  <= hit;
			res_count_q  <= count_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_status_q;
	assign res.found      = res_found_q;
	assign res.fill_count = res_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == ST_FULL) |-> res_count_q == COUNT_W'(CAPACITY))
		else $error("full status with store not full");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_found_q |-> (res_status_q == ST_DONE) && (res_count_q != '0))
		else $error("match reported on empty store or failed command");

	a_read_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SEARCH) && !res_valid_q)
		else $error("store read outstanding outside a search");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for bounded_deque_with_search: drives command words and checks every result word
// against a behavioural deque kept in the bench, under random source gaps and sink stalls.
// Depends on bdq_pkg, the channel interfaces in bdq_ifs and the block's RTL.
module tb;
	import bdq_pkg::*;

	localparam int DEPTH   = CAPACITY_DEF;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [COUNT_W-1:0]  fill_count;
	} deque_result_t;

	logic clk;
	logic arst_n;

	bdq_cmd_if cmd_ch ();
	bdq_res_if #(.COUNT_W(COUNT_W)) res_ch ();

	bounded_deque_with_search #(.CAPACITY(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// bench copy of the deque
	logic signed [DATA_W-1:0] ring_mem [DEPTH];
	int unsigned head_pos = 0;
	int unsigned n_stored = 0;

	deque_result_t pending_results [$];
	int unsigned mismatches = 0;

	int unsigned burst_left = 0;
	bit          gaps_on    = 1'b1;
	int unsigned hold_req   = 0;
	int unsigned hold_left  = 0;
	int unsigned stall_mode = 0;
	int unsigned mode_left  = 64;
	int unsigned phase_cnt  = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic deque_result_t apply_deque_op(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] val);
		deque_result_t r;
		r = '0;
		r.status = ST_DONE;
		case (op)
			CMD_PUSH_FRONT: begin
				if (n_stored >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					head_pos = (head_pos + DEPTH - 1) % DEPTH;
					ring_mem[IDX_W'(head_pos)] = val;
					n_stored++;
				end
			end
			CMD_PUSH_BACK: begin
				if (n_stored >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					ring_mem[IDX_W'((head_pos + n_stored) % DEPTH)] = val;
					n_stored++;
				end
			end
			CMD_POP_FRONT: begin
				if (n_stored == 0) begin
					r.status = ST_EMPTY;
				end else begin
					head_pos = (head_pos + 1) % DEPTH;
					n_stored--;
				end
			end
			CMD_POP_BACK: begin
				if (n_stored == 0) begin
					r.status = ST_EMPTY;
				end else begin
					n_stored--;
				end
			end
			CMD_SEARCH: begin
				for (int i = 0; i < n_stored; i++)
					if (ring_mem[IDX_W'((head_pos + i) % DEPTH)] == val)
						r.found = 1'b1;
			end
			default: begin
			end
		endcase
		r.fill_count = n_stored[COUNT_W-1:0];
		return r;
	endfunction

	// accepted commands are predicted before results are checked, so order within the edge is moot
	always @(posedge clk) begin
		deque_result_t got;
		deque_result_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				pending_results.push_back(apply_deque_op(cmd_ch.command, cmd_ch.data_value));
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.status, res_ch.found, res_ch.fill_count};
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: status=%0d found=%0d fill=%0d",
							got.status, got.found, got.fill_count);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp status=%0d found=%0d fill=%0d,",
								want.status, want.found, want.fill_count,
								" got status=%0d found=%0d fill=%0d",
								got.status, got.found, got.fill_count);
					end
				end
			end
		end
	end

	// sink stalls: a long hold when asked, otherwise a changing pattern
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= (phase_cnt % 4) == 0;
				default: res_ch.ready <= ((phase_cnt / 4) % 2) == 0;
			endcase
			phase_cnt++;
			mode_left--;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 200);
			end
		end
	end

	task automatic send_word(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] val);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left != 0)
			burst_left--;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= op;
		cmd_ch.data_value <= val;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic wait_all_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CMD_W-1:0] pick_op();
		int unsigned r;
		int unsigned push_pct;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			case ($urandom_range(0, 2))
				0: return CMD_RSVD_5;
				1: return CMD_RSVD_6;
				default: return CMD_RSVD_7;
			endcase
		end
		if (r < 25)
			return CMD_SEARCH;
		push_pct = (n_stored < 3) ? 80 : (n_stored > 13) ? 30 : 52;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
	endfunction

	// small pool gives duplicates and early hits
	function automatic logic signed [DATA_W-1:0] pick_value(input logic [CMD_W-1:0] op);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (op == CMD_SEARCH && n_stored != 0 && r < 55)
			return ring_mem[IDX_W'((head_pos + $urandom_range(0, n_stored - 1)) % DEPTH)];
		if (r < 30)
			return $signed($urandom_range(0, 7)) - 4;
		if (r < 40) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic test_directed();
		send_word(CMD_POP_FRONT, $urandom);
		send_word(CMD_POP_BACK, $urandom);
		send_word(CMD_SEARCH, '0);
		send_word(CMD_RSVD_5, $urandom);
		send_word(CMD_PUSH_FRONT, 32'h8000_0000);
		send_word(CMD_PUSH_BACK, 32'h7fff_ffff);
		send_word(CMD_PUSH_FRONT, '1);
		send_word(CMD_PUSH_BACK, '0);
		send_word(CMD_SEARCH, 32'h8000_0000);
		send_word(CMD_SEARCH, '0);
		send_word(CMD_SEARCH, '1);
		send_word(CMD_SEARCH, 32'sd1);
		send_word(CMD_RSVD_6, $urandom);
		send_word(CMD_RSVD_7, $urandom);
		send_word(CMD_POP_FRONT, $urandom);
		send_word(CMD_POP_BACK, $urandom);
		send_word(CMD_SEARCH, '0);
		send_word(CMD_SEARCH, 32'h7fff_ffff);
		wait_all_results();
	endtask

	// fill past full, search the whole store, then drain past empty
	task automatic test_fill_drain(input int unsigned rounds);
		int unsigned pushes;
		logic [CMD_W-1:0] op;
		repeat (rounds) begin
			wait_all_results();
			pushes = DEPTH - n_stored + 2;
			repeat (pushes) begin
				op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
				send_word(op, pick_value(op));
			end
			wait_all_results();
			send_word(CMD_SEARCH, ring_mem[IDX_W'((head_pos + DEPTH - 1) % DEPTH)]);
			send_word(CMD_SEARCH, $urandom);
			repeat (DEPTH + 2) begin
				op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
				send_word(op, $urandom);
			end
		end
		wait_all_results();
	endtask

	task automatic test_backpressure();
		logic [CMD_W-1:0] op;
		gaps_on = 1'b0;
		hold_req = 400;
		repeat (30) begin
			op = pick_op();
			send_word(op, pick_value(op));
		end
		wait_all_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_mix(input int unsigned words);
		logic [CMD_W-1:0] op;
		for (int unsigned k = 0; k < words; k++) begin
			if (k % 200 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			op = pick_op();
			send_word(op, pick_value(op));
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.command    <= CMD_PUSH_FRONT;
		cmd_ch.data_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain(3);
		test_backpressure();
		test_random_mix(600);
		test_fill_drain(2);
		test_random_mix(600);

		wait_all_results();
		repeat (24) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/bdq_pkg.sv
hdl/bdq_ifs.sv
hdl/bdq_ram.sv
hdl/bounded_deque_with_search.sv
bench/tb.sv
